### design/twe_pkg.sv
`default_nettype none

package twe_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SHAPE_COUNT   = 7;
    localparam int SHAPE_W       = 3;
    localparam int TBL_DEPTH     = SHAPE_COUNT * TABLE_ENTRIES;
    localparam int TBL_AW        = $clog2(TBL_DEPTH);

    // fixed point
    localparam logic signed [31:0] ONE_Q16   = 32'sd65536;
    localparam logic signed [16:0] ONE_Q14   = 17'sd16384;
    localparam logic signed [41:0] LERP_RATE = 42'sd597;

    // configuration register indexes
    localparam int CFG_COUNT = 8;
    localparam int CFG_IW    = $clog2(CFG_COUNT);
    localparam logic [CFG_IW-1:0] CFG_AMP       = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_AMP_ALT   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_FREQ      = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_FREQ_ALT  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_PHASE     = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_PHASE_ALT = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_LEVEL     = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_LEVEL_ALT = 3'd7;

    // blended parameter slots (pairs of registers)
    localparam int BL_AMP   = 0;
    localparam int BL_FREQ  = 1;
    localparam int BL_PHASE = 2;
    localparam int BL_LEVEL = 3;

    // operations
    localparam logic OP_EVAL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // wave types
    localparam logic [3:0] WT_NONE       = 4'd0;
    localparam logic [3:0] WT_SIN        = 4'd1;
    localparam logic [3:0] WT_HALFSIN    = 4'd2;
    localparam logic [3:0] WT_INVHALFSIN = 4'd3;
    localparam logic [3:0] WT_SAW        = 4'd4;
    localparam logic [3:0] WT_INVSAW     = 4'd5;
    localparam logic [3:0] WT_SQUARE     = 4'd6;
    localparam logic [3:0] WT_TRI        = 4'd7;
    localparam logic [3:0] WT_HILL       = 4'd8;
    localparam logic [3:0] WT_INVHILL    = 4'd9;

    // modes
    localparam logic [1:0] MD_TIME_WRAP     = 2'd0;
    localparam logic [1:0] MD_TIME_LERP     = 2'd1;
    localparam logic [1:0] MD_ELAPSED_WRAP  = 2'd2;
    localparam logic [1:0] MD_ELAPSED_CLAMP = 2'd3;

    // shape tables
    localparam logic [SHAPE_W-1:0] SH_SIN     = 3'd0;
    localparam logic [SHAPE_W-1:0] SH_HALFSIN = 3'd1;
    localparam logic [SHAPE_W-1:0] SH_SAW     = 3'd2;
    localparam logic [SHAPE_W-1:0] SH_INVSAW  = 3'd3;
    localparam logic [SHAPE_W-1:0] SH_SQUARE  = 3'd4;
    localparam logic [SHAPE_W-1:0] SH_TRI     = 3'd5;
    localparam logic [SHAPE_W-1:0] SH_HILL    = 3'd6;

    // per-stage transaction control carried down the pipeline
    typedef struct packed {
        logic                     op;
        logic                     bad;
        logic                     lerp;
        logic                     clamp;
        logic                     trunc;
        logic                     inv;
        logic [SHAPE_W-1:0]       shape;
        logic signed [31:0]       tval;
        logic [SHAPE_W-1:0]       sel;
        logic [IDX_W-1:0]         pos;
        logic [15:0]              data;
    } t_stg;

endpackage

`default_nettype wire

### design/table_waveform_evaluator_core.sv
`default_nettype none
// Throughput: one transaction per cycle unless the output stalls; each single-port table
//   memory is read or written once per cycle at a fixed pipeline stage (sine copy at
//   stage 1, shapes at 6).
// Reset: synchronous, active low; clears the pipeline and output valids and loads the
//   configuration reset values. Table contents are not initialized.

module table_waveform_evaluator_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data,
    // input channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_operation,
    input  wire logic [3:0]          i_wave_type,
    input  wire logic [1:0]          i_mode,
    input  wire logic signed [31:0]  i_time_value,
    input  wire logic [2:0]          i_table_select,
    input  wire logic [9:0]          i_table_index,
    input  wire logic signed [15:0]  i_table_data,
    // output channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [31:0]       o_wave_value,
    output logic                     o_bad_type
);

    localparam int NSTG    = 9;
    localparam int IDX_W   = twe_pkg::IDX_W;
    localparam int FRAC_SH = 32 - IDX_W;       // Q32.32 -> table index
    localparam int QW      = 65 - FRAC_SH;     // rounded index width

    function automatic logic signed [31:0] sat32(input logic signed [36:0] x);
        logic signed [31:0] y;
        if (x > 37'sd2147483647) begin
            y = 32'sh7fffffff;
        end else if (x < -37'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // ---------------- configuration ----------------
    logic signed [31:0] r_cfg [twe_pkg::CFG_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[twe_pkg::CFG_AMP]       <= twe_pkg::ONE_Q16;
            r_cfg[twe_pkg::CFG_AMP_ALT]   <= twe_pkg::ONE_Q16;
            r_cfg[twe_pkg::CFG_FREQ]      <= twe_pkg::ONE_Q16;
            r_cfg[twe_pkg::CFG_FREQ_ALT]  <= twe_pkg::ONE_Q16;
            r_cfg[twe_pkg::CFG_PHASE]     <= '0;
            r_cfg[twe_pkg::CFG_PHASE_ALT] <= '0;
            r_cfg[twe_pkg::CFG_LEVEL]     <= '0;
            r_cfg[twe_pkg::CFG_LEVEL_ALT] <= '0;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= $signed(i_cfg_data);
        end
    end

    // ---------------- pipeline control ----------------
    logic               r_vld [NSTG];
    twe_pkg::t_stg      r_stg [NSTG];
    twe_pkg::t_stg      w_dec;
    logic               w_adv;
    logic               w_last_res;
    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic               r_out_bad;

    assign w_last_res = r_vld[NSTG-1] && (r_stg[NSTG-1].op == twe_pkg::OP_EVAL);
    // stall only when a result is ready to leave and the output register is blocked
    assign w_adv      = !(w_last_res && r_out_valid && !i_out_ready);
    assign o_in_ready = w_adv;

    always_comb begin
        w_dec       = '0;
        w_dec.op    = i_operation;
        w_dec.tval  = i_time_value;
        w_dec.sel   = i_table_select;
        w_dec.pos   = i_table_index;
        w_dec.data  = i_table_data;
        w_dec.lerp  = (i_mode == twe_pkg::MD_TIME_LERP);
        w_dec.clamp = (i_mode == twe_pkg::MD_ELAPSED_CLAMP);
        w_dec.trunc = (i_wave_type == twe_pkg::WT_SIN) &&
                      (i_mode inside {twe_pkg::MD_TIME_WRAP, twe_pkg::MD_TIME_LERP});
        case (i_wave_type)
            twe_pkg::WT_SIN:        w_dec.shape = twe_pkg::SH_SIN;
            twe_pkg::WT_HALFSIN:    w_dec.shape = twe_pkg::SH_HALFSIN;
            twe_pkg::WT_INVHALFSIN: begin
                w_dec.shape = twe_pkg::SH_HALFSIN;
                w_dec.inv   = 1'b1;
            end
            twe_pkg::WT_SAW:        w_dec.shape = twe_pkg::SH_SAW;
            twe_pkg::WT_INVSAW:     w_dec.shape = twe_pkg::SH_INVSAW;
            twe_pkg::WT_SQUARE:     w_dec.shape = twe_pkg::SH_SQUARE;
            twe_pkg::WT_TRI:        w_dec.shape = twe_pkg::SH_TRI;
            twe_pkg::WT_HILL:       w_dec.shape = twe_pkg::SH_HILL;
            twe_pkg::WT_INVHILL: begin
                w_dec.shape = twe_pkg::SH_HILL;
                w_dec.inv   = 1'b1;
            end
            default:                w_dec.bad   = 1'b1;
        endcase
        // half-sine shapes have no elapsed-time form
        if ((i_mode inside {twe_pkg::MD_ELAPSED_WRAP, twe_pkg::MD_ELAPSED_CLAMP}) &&
            (i_wave_type inside {twe_pkg::WT_HALFSIN, twe_pkg::WT_INVHALFSIN})) begin
            w_dec.bad = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_stg[0] <= w_dec;
            for (int k = 1; k < NSTG; k++) begin
                r_stg[k] <= r_stg[k-1];
            end
        end
    end

    // ---------------- stage 0: lerp position t*597 ----------------
    logic signed [41:0] w_p;
    logic signed [41:0] r_p;

    assign w_p = 42'(r_stg[0].tval) * twe_pkg::LERP_RATE;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p <= w_p;
        end
    end

    // ---------------- stage 1: sine copy access ----------------
    logic [IDX_W-1:0] w_li;
    logic [IDX_W-1:0] w_sin_addr;
    logic             w_sin_we;
    logic [15:0]      w_sin_rdata;

    // truncation toward zero, then wrap to the table
    assign w_li = r_p[16 +: IDX_W] + IDX_W'(r_p[41] && (|r_p[15:0]));
    assign w_sin_we = r_vld[1] && (r_stg[1].op == twe_pkg::OP_WRITE) &&
                      (r_stg[1].sel == twe_pkg::SH_SIN);
    assign w_sin_addr = (r_stg[1].op == twe_pkg::OP_WRITE) ? r_stg[1].pos : w_li;

    twe_ram #(
        .WIDTH (16),
        .DEPTH (twe_pkg::TABLE_ENTRIES)
    ) u_sin_ram (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_we    (w_sin_we),
        .i_addr  (w_sin_addr),
        .i_wdata (r_stg[1].data),
        .o_rdata (w_sin_rdata)
    );

    // ---------------- stage 2: blend products ----------------
    logic signed [16:0] w_w2;
    logic signed [32:0] w_diff [4];
    logic signed [49:0] w_bp   [4];
    logic signed [49:0] r_bp   [4];

    assign w_w2 = 17'($signed(w_sin_rdata)) + twe_pkg::ONE_Q14;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_diff[k] = 33'(r_cfg[2*k+1]) - 33'(r_cfg[2*k]);
            w_bp[k]   = 50'(w_diff[k]) * 50'(w_w2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 4; k++) begin
                r_bp[k] <= w_bp[k];
            end
        end
    end

    // ---------------- stage 3: blend finish ----------------
    logic signed [50:0] w_brnd [4];
    logic signed [36:0] w_bsum [4];
    logic signed [31:0] r_bl   [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_brnd[k] = 51'(r_bp[k]) + 51'sd16384;
            w_bsum[k] = 37'(r_cfg[2*k]) + 37'($signed(w_brnd[k][50:15]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 4; k++) begin
                r_bl[k] <= r_stg[3].lerp ? sat32(w_bsum[k]) : r_cfg[2*k];
            end
        end
    end

    // ---------------- stage 4: t*freq ----------------
    logic signed [63:0] w_tf;
    logic signed [63:0] r_tf;
    logic signed [31:0] r_ph5;
    logic signed [31:0] r_amp5, r_amp6, r_amp7;
    logic signed [31:0] r_lvl5, r_lvl6, r_lvl7, r_lvl8;

    assign w_tf = 64'(r_stg[4].tval) * 64'(r_bl[twe_pkg::BL_FREQ]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tf   <= w_tf;
            r_ph5  <= r_bl[twe_pkg::BL_PHASE];
            r_amp5 <= r_bl[twe_pkg::BL_AMP];
            r_lvl5 <= r_bl[twe_pkg::BL_LEVEL];
        end
    end

    // ---------------- stage 5: add phase ----------------
    logic signed [63:0] r_s;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s    <= r_tf + $signed({{16{r_ph5[31]}}, r_ph5, 16'd0});
            r_amp6 <= r_amp5;
            r_lvl6 <= r_lvl5;
        end
    end

    // ---------------- stage 6: index and shape table access ----------------
    logic [IDX_W-1:0]          w_qt;
    logic signed [64:0]        w_sr;
    logic [QW-1:0]             w_qr;
    logic [IDX_W-1:0]          w_qc;
    logic [IDX_W-1:0]          w_idx;
    logic [twe_pkg::TBL_AW-1:0] w_tbl_addr;
    logic                      w_tbl_we;
    logic [15:0]               w_tbl_rdata;

    assign w_qt = r_s[FRAC_SH +: IDX_W] + IDX_W'(r_s[63] && (|r_s[FRAC_SH-1:0]));
    assign w_sr = 65'(r_s) + (65'sd1 <<< (FRAC_SH - 1));
    assign w_qr = w_sr[64:FRAC_SH];

    always_comb begin
        if (w_qr[QW-1]) begin
            w_qc = '0;
        end else if (|w_qr[QW-2:IDX_W]) begin
            w_qc = '1;
        end else begin
            w_qc = w_qr[IDX_W-1:0];
        end
        if (r_stg[6].trunc) begin
            w_idx = w_qt;
        end else if (r_stg[6].clamp) begin
            w_idx = w_qc;
        end else begin
            w_idx = w_qr[IDX_W-1:0];
        end
    end

    assign w_tbl_we   = r_vld[6] && (r_stg[6].op == twe_pkg::OP_WRITE) &&
                        (r_stg[6].sel < twe_pkg::SHAPE_W'(twe_pkg::SHAPE_COUNT));
    assign w_tbl_addr = (r_stg[6].op == twe_pkg::OP_WRITE) ?
                        twe_pkg::TBL_AW'({r_stg[6].sel, r_stg[6].pos}) :
                        twe_pkg::TBL_AW'({r_stg[6].shape, w_idx});

    twe_ram #(
        .WIDTH (16),
        .DEPTH (twe_pkg::TBL_DEPTH)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_we    (w_tbl_we),
        .i_addr  (w_tbl_addr),
        .i_wdata (r_stg[6].data),
        .o_rdata (w_tbl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_amp7 <= r_amp6;
            r_lvl7 <= r_lvl6;
        end
    end

    // ---------------- stage 7: amp * entry ----------------
    logic signed [16:0] w_e;
    logic signed [48:0] r_ae;

    assign w_e = r_stg[7].inv ? (twe_pkg::ONE_Q14 - 17'($signed(w_tbl_rdata))) :
                                17'($signed(w_tbl_rdata));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ae   <= 49'(r_amp7) * 49'(w_e);
            r_lvl8 <= r_lvl7;
        end
    end

    // ---------------- stage 8: round, add level, output register ----------------
    logic signed [49:0] w_arnd;
    logic signed [36:0] w_vsum;

    assign w_arnd = 50'(r_ae) + 50'sd8192;
    assign w_vsum = 37'($signed(w_arnd[49:14])) + 37'(r_lvl8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_last_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last_res) begin
            r_out_bad   <= r_stg[NSTG-1].bad;
            r_out_value <= r_stg[NSTG-1].bad ? twe_pkg::ONE_Q16 : sat32(w_vsum);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_wave_value = r_out_value;
    assign o_bad_type   = r_out_bad;

    // ---------------- assertions ----------------
    a_ready_only_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a blocked output");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && (r_stg[NSTG-1].op == twe_pkg::OP_EVAL) && o_in_ready)
        |=> o_out_valid)
        else $error("finished result not loaded into output register");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && (r_stg[NSTG-1].op == twe_pkg::OP_WRITE) && o_in_ready &&
         (!o_out_valid || i_out_ready)) |=> !o_out_valid)
        else $error("table write produced a result");

    a_bad_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_type) |-> (o_wave_value == twe_pkg::ONE_Q16))
        else $error("bad type result is not 1.0");

endmodule

`default_nettype wire

### design/twe_ram.sv
`default_nettype none

module twe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
